FILE: hw/rtl/wma_pkg.sv
// package for the weighted moving average block
// holds field widths, reset values and the sequencer state type; no dependencies

package wma_pkg;

    // field widths fixed by the item layout
    localparam int WMA_DATA_W   = 32;
    localparam int WMA_PERIOD_W = 7;

    // default window depth and register reset value
    localparam int                  WMA_MAX_PERIOD   = 64;
    localparam logic [WMA_PERIOD_W-1:0] WMA_PERIOD_RESET = 7'd30;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_DONE
    } t_wma_state;

endpackage

FILE: hw/rtl/wma_divider.sv
// bit-serial signed divider, one quotient bit per cycle, truncates toward zero
// signed dividend, positive divisor; standalone, uses no package items

module wma_divider #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic             r_neg;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;

    logic [NUM_W-1:0] w_mag;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W:0]   n_rem;

    // magnitude of the dividend
    assign w_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);

    // one restoring step: shift in the next dividend bit and try to subtract
    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: dividend bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_neg <= i_num[NUM_W-1];
            r_q   <= w_mag;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= n_rem;
            r_q   <= {r_q[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? $signed(-r_q) : $signed(r_q);

endmodule

FILE: hw/rtl/weighted_moving_average.sv
// top level of the linear weighted moving average over Q16.16 price samples
// depends on wma_pkg and wma_divider
//
//  channel  | direction | tdata / data      | tuser         | accepted when
//  ---------+-----------+-------------------+---------------+---------------------------
//  s_axis   | in        | price [31:0]      | price_missing | s_axis_tvalid & tready
//  m_axis   | out       | average [31:0]    | average_valid | m_axis_tvalid & tready
//  cfg      | in        | period [6:0]      | -             | i_cfg_valid & o_cfg_ready
//
// missing sample or window not yet full: the sequencer goes from idle straight to done, no mac or divide.
// full window: one mac pass over the window memory, one entry per cycle, then the bit-serial
// divider at one quotient bit per cycle (ACC_W = 45 at MAX_PERIOD 64).
// synchronous active-low reset sets period to 30 and empties the window.
// one item in work at a time; a result waits in the output register, the sequencer holds if full.

module weighted_moving_average
    import wma_pkg::*;
#(
    parameter int MAX_PERIOD = WMA_MAX_PERIOD
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input samples
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [WMA_DATA_W-1:0]   s_axis_tdata,  // [31:0] price
    input  logic                    s_axis_tuser,  // [0] price_missing
    // results
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [WMA_DATA_W-1:0]   m_axis_tdata,  // [31:0] average
    output logic                    m_axis_tuser,  // [0] average_valid
    // period register write
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [WMA_PERIOD_W-1:0] i_cfg_data
);

    localparam int PW     = $clog2(MAX_PERIOD + 1);
    localparam int SW     = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int SUM_W  = $clog2(MAX_PERIOD * (MAX_PERIOD + 1) / 2 + 1);
    localparam int ACC_W  = WMA_DATA_W + 1 + SUM_W;
    localparam int PROD_W = WMA_DATA_W + 1 + PW;

    t_wma_state r_state, n_state;

    logic [WMA_PERIOD_W-1:0] r_period;
    logic [PW-1:0]           r_fill;
    logic [SW-1:0]           r_slot;

    // window memory and mac pipeline
    logic [WMA_DATA_W-1:0]    r_mem [MAX_PERIOD];
    logic [SW-1:0]            r_rd_slot;
    logic [PW:0]              r_wt;
    logic                     r_v1, r_v2;
    logic [WMA_DATA_W-1:0]    r_mem_q;
    logic [PW-1:0]            r_wt_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [SUM_W-1:0]         r_den;

    // pending result and output register
    logic [WMA_DATA_W-1:0] r_res_avg;
    logic                  r_res_ok;
    logic                  r_out_valid;
    logic [WMA_DATA_W-1:0] r_out_data;
    logic                  r_out_user;

    logic [PW-1:0]      w_p;
    logic [2*PW:0]      w_pp;
    logic [SW-1:0]      w_slot_w;
    logic [SW-1:0]      w_slot_nx;
    logic [PW-1:0]      w_fill_nx;
    logic               w_full;
    logic               w_in_acc;
    logic               w_cfg_acc;
    logic               w_issue;
    logic               w_drained;
    logic               w_div_start;
    logic               w_div_done;
    logic signed [ACC_W-1:0] w_quo;
    logic               w_load_out;
    logic               w_ready_in;
    logic               w_cfg_ready;

    // effective period, saturated to 1..MAX_PERIOD
    always_comb begin
        if (r_period == '0) begin
            w_p = PW'(1);
        end else if (int'(r_period) > MAX_PERIOD) begin
            w_p = PW'(MAX_PERIOD);
        end else begin
            w_p = PW'(r_period);
        end
    end

    // twice the sum of weights: p*(p+1)
    assign w_pp = (2*PW+1)'(w_p) * (2*PW+1)'((PW+1)'(w_p) + 1'b1);

    // ring write position, next position and fill level on a present sample
    always_comb begin
        w_slot_w  = (PW'(r_slot) >= w_p) ? '0 : r_slot;
        w_slot_nx = (((PW+1)'(w_slot_w) + 1'b1) >= (PW+1)'(w_p)) ? '0
                                                                 : w_slot_w + 1'b1;
        w_fill_nx = (r_fill < w_p) ? r_fill + 1'b1 : r_fill;
        w_full    = (w_fill_nx >= w_p);
    end

    assign w_in_acc  = s_axis_tvalid & w_ready_in;
    assign w_cfg_acc = i_cfg_valid & w_cfg_ready;
    assign w_drained = !w_issue && !r_v1 && !r_v2;

    // sequencer outputs
    always_comb begin
        w_ready_in  = 1'b0;
        w_cfg_ready = 1'b0;
        w_issue     = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_cfg_ready = 1'b1;
                w_ready_in  = !i_cfg_valid;
            end
            ST_MAC: begin
                w_issue     = (r_wt <= (PW+1)'(w_p));
                w_div_start = !(r_wt <= (PW+1)'(w_p)) && !r_v1 && !r_v2;
            end
            ST_DONE: begin
                w_load_out = !r_out_valid || m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (!s_axis_tuser && w_full) begin
                        n_state = ST_MAC;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MAC: begin
                if (w_drained) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_period    <= WMA_PERIOD_RESET;
            r_fill      <= '0;
            r_slot      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            if (w_cfg_acc) begin
                r_period <= i_cfg_data;
                r_fill   <= '0;
                r_slot   <= '0;
            end else if (w_in_acc && !s_axis_tuser) begin
                r_fill <= w_fill_nx;
                r_slot <= w_slot_nx;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window memory: write on a present sample, registered read for the mac pass
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !s_axis_tuser) begin
            r_mem[w_slot_w] <= s_axis_tdata;
        end
        r_mem_q <= r_mem[r_rd_slot];
    end

    // mac pass from oldest (weight 1) to newest (weight p)
    always_ff @(posedge i_clk) begin
        r_den <= SUM_W'(w_pp >> 1);
        if (w_in_acc) begin
            r_rd_slot <= w_slot_nx;
            r_wt      <= (PW+1)'(1);
            r_acc     <= '0;
        end else begin
            if (w_issue) begin
                r_rd_slot <= (((PW+1)'(r_rd_slot) + 1'b1) >= (PW+1)'(w_p)) ? '0
                                                                          : r_rd_slot + 1'b1;
                r_wt      <= r_wt + 1'b1;
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        r_wt_q <= PW'(r_wt);
        r_prod <= $signed(r_mem_q) * $signed({1'b0, r_wt_q});
    end

    wma_divider #(
        .NUM_W (ACC_W),
        .DEN_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_acc),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // pending result and output register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res_avg <= '0;
            r_res_ok  <= !s_axis_tuser && w_full;
        end else if (r_state == ST_DIV && w_div_done) begin
            r_res_avg <= WMA_DATA_W'(w_quo);
        end
        if (w_load_out) begin
            r_out_data <= r_res_avg;
            r_out_user <= r_res_ok;
        end
    end

    assign s_axis_tready = w_ready_in;
    assign o_cfg_ready   = w_cfg_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
